// ----- rtl/sample_block_statistics_core_defines.svh -----
// assertion macros for the sample block statistics core
// used by sbs_ctrl and sbs_dpath; expects clk and rst_n in scope
`ifndef SAMPLE_BLOCK_STATISTICS_CORE_DEFINES_SVH
`define SAMPLE_BLOCK_STATISTICS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// consequence must hold in the same cycle as the antecedent
`define SBS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sample block statistics: assertion failed");
// consequence must hold in the cycle after the antecedent
`define SBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sample block statistics: assertion failed");
`else
`define SBS_ASSERT_NOW(lbl, ante, cons)
`define SBS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/sbs_pkg.sv -----
// shared types and constants for the sample block statistics core
// no dependencies
package sbs_pkg;

  // result field widths
  localparam int COUNT_FIELD_W = 13;
  localparam int VALUE_FIELD_W = 16;
  localparam int OUT_PAD_W     = 3;
  localparam int OUT_TDATA_W   = COUNT_FIELD_W + 4 * VALUE_FIELD_W + OUT_PAD_W;

  // result word, last field (sample_count) in the lowest bits
  typedef struct packed {
    logic [OUT_PAD_W-1:0]     pad;
    logic [VALUE_FIELD_W-1:0] std_dev;
    logic [VALUE_FIELD_W-1:0] mean;
    logic [VALUE_FIELD_W-1:0] maximum;
    logic [VALUE_FIELD_W-1:0] minimum;
    logic [COUNT_FIELD_W-1:0] sample_count;
  } sbs_result_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accum;          // take one sample into the accumulators
    logic mul_load_n;     // start count * sum of squares
    logic mul_load_s;     // start subtraction of sum squared
    logic mul_step;       // one shift-add step
    logic sqrt_load;      // clear root and remainder
    logic sqrt_step;      // one root digit
    logic div_load_sd;    // divide root by count
    logic div_load_mean;  // divide sum magnitude by count
    logic div_step;       // one quotient bit
    logic sd_save;        // keep deviation quotient
    logic out_load;       // fill output register, clear burst
  } sbs_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ovf;
  } sbs_stat_t;

  // controller states
  typedef enum logic [10:0] {
    ST_ACCUM     = 11'b000_0000_0001,
    ST_START     = 11'b000_0000_0010,
    ST_MUL_N     = 11'b000_0000_0100,
    ST_LOAD_S    = 11'b000_0000_1000,
    ST_MUL_S     = 11'b000_0001_0000,
    ST_SQRT      = 11'b000_0010_0000,
    ST_LOAD_SD   = 11'b000_0100_0000,
    ST_DIV_SD    = 11'b000_1000_0000,
    ST_LOAD_MEAN = 11'b001_0000_0000,
    ST_DIV_MEAN  = 11'b010_0000_0000,
    ST_DONE      = 11'b100_0000_0000
  } sbs_state_t;

endpackage

// ----- rtl/sbs_ctrl.sv -----
// controller state machine for the sample block statistics core
// depends on sbs_pkg and the core defines header
`include "sample_block_statistics_core_defines.svh"

module sbs_ctrl #(
  parameter int SHORT_STEPS = 13,
  parameter int LONG_STEPS  = 29
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output sbs_pkg::sbs_cmd_t cmd,
  input  sbs_pkg::sbs_stat_t stat
);
  import sbs_pkg::*;

  localparam int STEP_W = $clog2(LONG_STEPS);

  sbs_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  // next state and command decode
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '0;
    case (state_r)
      ST_ACCUM: begin
        cmd.accum = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (stat.ovf) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.mul_load_n = 1'b1;
          step_nxt       = STEP_W'(SHORT_STEPS - 1);
          state_nxt      = ST_MUL_N;
        end
      end
      ST_MUL_N: begin
        cmd.mul_step = 1'b1;
        step_nxt     = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_LOAD_S;
        end
      end
      ST_LOAD_S: begin
        cmd.mul_load_s = 1'b1;
        cmd.sqrt_load  = 1'b1;
        step_nxt       = STEP_W'(LONG_STEPS - 1);
        state_nxt      = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.mul_step = 1'b1;
        step_nxt     = step_r - 1'b1;
        if (step_r == '0) begin
          step_nxt  = STEP_W'(LONG_STEPS - 1);
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_LOAD_SD;
        end
      end
      ST_LOAD_SD: begin
        cmd.div_load_sd = 1'b1;
        step_nxt        = STEP_W'(LONG_STEPS - 1);
        state_nxt       = ST_DIV_SD;
      end
      ST_DIV_SD: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_LOAD_MEAN;
        end
      end
      ST_LOAD_MEAN: begin
        cmd.sd_save       = 1'b1;
        cmd.div_load_mean = 1'b1;
        step_nxt          = STEP_W'(LONG_STEPS - 1);
        state_nxt         = ST_DIV_MEAN;
      end
      ST_DIV_MEAN: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_ACCUM);
  assign out_tvalid = out_valid_r;

  // a marked sample always starts the result sequence
  `SBS_ASSERT_NEXT(a_last_starts, cmd.accum && in_tlast, state_r == ST_START)
  // a waiting result is never overwritten
  `SBS_ASSERT_NOW(a_no_overwrite, out_valid_r && !out_tready, !cmd.out_load)
  // after a result is loaded the block is back to taking samples
  `SBS_ASSERT_NEXT(a_done_exits, cmd.out_load, out_valid_r && state_r == ST_ACCUM)

endmodule

// ----- rtl/sbs_dpath.sv -----
// datapath of the sample block statistics core: accumulators, shared
// bit-serial multiplier, square root and divider, output register
// depends on sbs_pkg and the core defines header
`include "sample_block_statistics_core_defines.svh"

module sbs_dpath #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 16,
  parameter int IN_TDATA_W  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [IN_TDATA_W-1:0]            in_tdata,
  input  sbs_pkg::sbs_cmd_t                cmd,
  output sbs_pkg::sbs_stat_t               stat,
  output logic [sbs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser
);
  import sbs_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
  localparam int VAR_W  = 2 * SUM_W;
  localparam int ROOT_W = SUM_W;
  localparam int DIV_W  = SUM_W;

  // burst accumulators
  logic        [CNT_W-1:0]       count_r, count_nxt;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt;
  logic        [SQ_W-1:0]        sumsq_r, sumsq_nxt;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt;
  logic                          ovf_r, ovf_nxt;

  // shared working registers
  logic [VAR_W-1:0]  acc_r, acc_nxt;
  logic [VAR_W-1:0]  mcand_r, mcand_nxt;
  logic [SUM_W-1:0]  mplier_r, mplier_nxt;
  logic              sub_r, sub_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [ROOT_W+1:0] srem_r, srem_nxt;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt;
  logic [CNT_W-1:0]  drem_r, drem_nxt;
  logic [VALUE_FIELD_W-1:0] sd_r, sd_nxt;
  sbs_result_t       res_r, res_nxt;
  logic              res_ovf_r, res_ovf_nxt;

  logic signed [SAMPLE_BITS-1:0]   sample;
  logic signed [2*SAMPLE_BITS-1:0] sample_sq;
  logic [SUM_W-1:0]  abs_sum;
  logic [ROOT_W+1:0] sq_shift, sq_trial;
  logic              sq_ge;
  logic [CNT_W:0]    dv_shift;
  logic              dv_ge;
  logic [DIV_W:0]    q_mag;
  logic signed [DIV_W:0] mean_full;

  assign sample    = $signed(in_tdata[SAMPLE_BITS-1:0]);
  assign sample_sq = sample * sample;
  assign abs_sum   = sum_r[SUM_W-1] ? $unsigned(-sum_r) : $unsigned(sum_r);

  // clear on result load; else accumulate one sample, dropping it and flagging overflow once the burst is full
  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    ovf_nxt   = ovf_r;
    if (cmd.out_load) begin
      count_nxt = '0;
      sum_nxt   = '0;
      sumsq_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (cmd.accum) begin
      if (count_r >= CNT_W'(MAX_SAMPLES)) begin
        ovf_nxt = 1'b1;
      end else begin
        if (count_r == '0) begin
          min_nxt = sample;
          max_nxt = sample;
        end else begin
          if (sample < min_r) min_nxt = sample;
          if (sample > max_r) max_nxt = sample;
        end
        sum_nxt   = sum_r + SUM_W'(sample);
        sumsq_nxt = sumsq_r + SQ_W'($unsigned(sample_sq));
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // root step: bring down two bits, try the next digit
  assign sq_shift = {srem_r[ROOT_W-1:0], acc_r[VAR_W-1 -: 2]};
  assign sq_trial = {root_r, 2'b01};
  assign sq_ge    = (sq_shift >= sq_trial);

  // divide step: bring down one bit, compare with count
  assign dv_shift = {drem_r, dvd_r[DIV_W-1]};
  assign dv_ge    = (dv_shift >= {1'b0, count_r});

  // multiplier, root and divider sequencing
  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    sub_nxt    = sub_r;
    root_nxt   = root_r;
    srem_nxt   = srem_r;
    dvd_nxt    = dvd_r;
    drem_nxt   = drem_r;
    sd_nxt     = sd_r;
    // variance numerator: count * sum_sq - sum * sum
    if (cmd.mul_load_n) begin
      acc_nxt    = '0;
      mcand_nxt  = VAR_W'(sumsq_r);
      mplier_nxt = SUM_W'(count_r);
      sub_nxt    = 1'b0;
    end else if (cmd.mul_step) begin
      if (mplier_r[0]) begin
        acc_nxt = sub_r ? (acc_r - mcand_r) : (acc_r + mcand_r);
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
    end else if (cmd.sqrt_step) begin
      acc_nxt = acc_r << 2;
    end
    if (cmd.mul_load_s) begin
      mcand_nxt  = VAR_W'(abs_sum);
      mplier_nxt = abs_sum;
      sub_nxt    = 1'b1;
    end
    // integer square root, one digit a cycle
    if (cmd.sqrt_load) begin
      root_nxt = '0;
      srem_nxt = '0;
    end else if (cmd.sqrt_step) begin
      srem_nxt = sq_ge ? (sq_shift - sq_trial) : sq_shift;
      root_nxt = {root_r[ROOT_W-2:0], sq_ge};
    end
    // restoring divider by the count
    if (cmd.div_load_sd) begin
      dvd_nxt  = root_r;
      drem_nxt = '0;
    end else if (cmd.div_load_mean) begin
      dvd_nxt  = abs_sum;
      drem_nxt = '0;
    end else if (cmd.div_step) begin
      drem_nxt = dv_ge ? CNT_W'(dv_shift - {1'b0, count_r}) : dv_shift[CNT_W-1:0];
      dvd_nxt  = {dvd_r[DIV_W-2:0], dv_ge};
    end
    if (cmd.sd_save) begin
      sd_nxt = VALUE_FIELD_W'(dvd_r);
    end
  end

  // floor mean: round the magnitude up for a negative sum with remainder
  assign q_mag     = {1'b0, dvd_r} + (DIV_W + 1)'(sum_r[SUM_W-1] && (drem_r != '0));
  assign mean_full = sum_r[SUM_W-1] ? -$signed(q_mag) : $signed(q_mag);

  // result word
  always_comb begin
    res_nxt     = res_r;
    res_ovf_nxt = res_ovf_r;
    if (cmd.out_load) begin
      res_nxt              = '0;
      res_nxt.sample_count = COUNT_FIELD_W'(count_r);
      res_ovf_nxt          = ovf_r;
      if (!ovf_r) begin
        res_nxt.minimum = VALUE_FIELD_W'(min_r);
        res_nxt.maximum = VALUE_FIELD_W'(max_r);
        res_nxt.mean    = VALUE_FIELD_W'(mean_full);
        res_nxt.std_dev = sd_r;
      end
    end
  end

  // accumulator registers with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    min_r     <= min_nxt;
    max_r     <= max_nxt;
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    mplier_r  <= mplier_nxt;
    sub_r     <= sub_nxt;
    root_r    <= root_nxt;
    srem_r    <= srem_nxt;
    dvd_r     <= dvd_nxt;
    drem_r    <= drem_nxt;
    sd_r      <= sd_nxt;
    res_r     <= res_nxt;
    res_ovf_r <= res_ovf_nxt;
  end

  assign stat.ovf  = ovf_r;
  assign out_tdata = res_r;
  assign out_tuser = res_ovf_r;

  // count saturates at the burst limit
  `SBS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_SAMPLES))
  // overflow only ever seen with a full burst
  `SBS_ASSERT_NOW(a_ovf_full, ovf_r, count_r == CNT_W'(MAX_SAMPLES))
  // running extremes stay ordered once a sample is in
  `SBS_ASSERT_NEXT(a_min_le_max, cmd.accum, min_r <= max_r)

endmodule

// ----- rtl/sample_block_statistics_core.sv -----
// top level of the sample block statistics core
// depends on sbs_pkg, sbs_ctrl and sbs_dpath

// Takes a burst of signed Q8.8 samples at one per cycle, the last marked
// with in_tlast, and returns one word with count, minimum, maximum, floor
// mean and floor population standard deviation; out_tuser flags a burst
// longer than MAX_SAMPLES, in which case only the count is meaningful.
// After the marked sample in_tready stays low until the result is loaded
// into the output register; the result is computed by one shared
// bit-serial multiplier, a digit-serial square root and a one-bit-per-cycle
// divider used twice, and an overflowed burst skips that arithmetic.
// The result sits in an output register, so the next burst is accumulated
// while it waits; only the next result waits for it to be taken.
module sample_block_statistics_core #(
  parameter int MAX_SAMPLES = 4096,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [IN_TDATA_W-1:0]           in_tdata,   // sample
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // sample_count, minimum, maximum, mean, std_dev, zero pad
  output logic [sbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser   // overflow
);
  import sbs_pkg::*;

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  sbs_cmd_t  cmd;
  sbs_stat_t stat;

  // sequencer
  sbs_ctrl #(
    .SHORT_STEPS (CNT_W),
    .LONG_STEPS  (SAMPLE_BITS + CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // arithmetic and result register
  sbs_dpath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IN_TDATA_W  (IN_TDATA_W)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
